// ===== src/tmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the model matrix composer.
// Used by tmc_cordic and trs_model_matrix_compose_top.
package tmc_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_COUNT        = 24;
  localparam int TRIG_BITS         = 30;
  localparam int TW                = 34;  // trig and matrix entry width
  localparam int ZW                = 33;  // CORDIC angle accumulator width
  localparam int PW                = 68;  // full product width
  localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
  } side_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // round half up, then floor shift
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int n);
    logic signed [PW-1:0] half;
    half = PW'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > PW'(64'sd2147483647)) r = 32'sh7FFFFFFF;
    else if (v < -PW'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/tmc_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one binary angle in, sine and cosine out.
// Depends on tmc_pkg. One pipeline stage per micro-rotation, between an input register and an output register.
module tmc_cordic import tmc_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          angle,
  output logic signed [TW-1:0] sin_q,
  output logic signed [TW-1:0] cos_q
);

  localparam int N  = CORDIC_STAGES;
  localparam int SH = TRIG_BITS - FRAC_BITS;

  logic signed [TW-1:0] xs [0:N];
  logic signed [TW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic                 ng [0:N];

  logic [31:0] z_fold;
  logic        fold;

  always_comb begin
    fold   = (angle[15:14] == 2'd1) || (angle[15:14] == 2'd2);
    z_fold = {angle, 16'h0} - (fold ? 32'h80000000 : 32'h0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= ZW'($signed(z_fold));
      ng[0] <= fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ZW'(atan_val(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ZW'(atan_val(i));
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  logic signed [TW-1:0] xr, yr;

  always_comb begin
    xr = (xs[N] + (TW'(1) <<< (SH - 1))) >>> SH;
    yr = (ys[N] + (TW'(1) <<< (SH - 1))) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= ng[N] ? -xr : xr;
      sin_q <= ng[N] ? -yr : yr;
    end
  end

endmodule

// ===== src/trs_model_matrix_compose_top.sv =====
`timescale 1ns / 1ps
// Top level of the model matrix composer: CORDIC front end, product stages, output.
// Depends on tmc_pkg and tmc_cordic.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | pos_*, angle_*, scale_*
//  out     | out_valid/out_stall | r00..r22, trans_*
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (origin_x/y/z)
//
// One item per cycle while the output is not stalled; the path runs through the CORDIC
// stages, then three product stages and the output register.
// Reset clears valid bits and loads the origin registers with one half.
// A stalled output freezes the whole pipeline; in_stall follows at once.
module trs_model_matrix_compose_top import tmc_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [15:0] angle_x,
  input  logic [15:0] angle_y,
  input  logic [15:0] angle_z,
  input  logic [31:0] scale_x,
  input  logic [31:0] scale_y,
  input  logic [31:0] scale_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] r00,
  output logic [31:0] r01,
  output logic [31:0] r02,
  output logic [31:0] r10,
  output logic [31:0] r11,
  output logic [31:0] r12,
  output logic [31:0] r20,
  output logic [31:0] r21,
  output logic [31:0] r22,
  output logic [31:0] trans_x,
  output logic [31:0] trans_y,
  output logic [31:0] trans_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int L = CORDIC_STAGES + 2;

  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // origin registers
  logic signed [31:0] org [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) org[k] <= 32'(1 << (FRAC_BITS - 1));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // CORDIC front end
  logic signed [TW-1:0] sxq, cxq, syq, cyq, szq, czq;

  tmc_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cx (
    .clk(clk), .en(en), .angle(angle_x), .sin_q(sxq), .cos_q(cxq));
  tmc_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cy (
    .clk(clk), .en(en), .angle(angle_y), .sin_q(syq), .cos_q(cyq));
  tmc_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cz (
    .clk(clk), .en(en), .angle(angle_z), .sin_q(szq), .cos_q(czq));

  logic [L-1:0] vc;
  side_t        sd [0:L-1];

  always_ff @(posedge clk) begin
    if (rst) vc <= '0;
    else if (en) vc <= {vc[L-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= '{px: pos_x, py: pos_y, pz: pos_z, sx: scale_x, sy: scale_y, sz: scale_z};
      for (int k = 1; k < L; k++) sd[k] <= sd[k-1];
    end
  end

  // stage A: first products and scaled pivot
  logic                 va;
  side_t                sa;
  logic signed [TW-1:0] a_t, a_u, a_cycz, a_cysz, a_cxsz, a_cxcz, a_sxcy;
  logic signed [TW-1:0] a_sxsz, a_sxcz, a_cxcy, a_sy, a_cz, a_sz;
  logic signed [31:0]   a_op [3];

  function automatic logic signed [TW-1:0] mq(input logic signed [TW-1:0] a,
                                              input logic signed [TW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return TW'(rnd(p, FRAC_BITS));
  endfunction

  function automatic logic signed [31:0] opq(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return sat32(rnd(p, FRAC_BITS));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vc[L-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa     <= sd[L-1];
      a_t    <= mq(sxq, syq);
      a_u    <= mq(cxq, syq);
      a_cycz <= mq(cyq, czq);
      a_cysz <= mq(cyq, szq);
      a_cxsz <= mq(cxq, szq);
      a_cxcz <= mq(cxq, czq);
      a_sxcy <= mq(sxq, cyq);
      a_sxsz <= mq(sxq, szq);
      a_sxcz <= mq(sxq, czq);
      a_cxcy <= mq(cxq, cyq);
      a_sy   <= syq;
      a_cz   <= czq;
      a_sz   <= szq;
      a_op[0] <= opq(org[0], sd[L-1].sx);
      a_op[1] <= opq(org[1], sd[L-1].sy);
      a_op[2] <= opq(org[2], sd[L-1].sz);
    end
  end

  // stage B: rotation entries
  logic                 vb;
  side_t                sb;
  logic signed [TW-1:0] rm [3][3];
  logic signed [31:0]   b_op [3];

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb       <= sa;
      b_op     <= a_op;
      rm[0][0] <= a_cycz;
      rm[0][1] <= -a_cysz;
      rm[0][2] <= a_sy;
      rm[1][0] <= a_cxsz + mq(a_t, a_cz);
      rm[1][1] <= a_cxcz - mq(a_t, a_sz);
      rm[1][2] <= -a_sxcy;
      rm[2][0] <= a_sxsz - mq(a_u, a_cz);
      rm[2][1] <= a_sxcz + mq(a_u, a_sz);
      rm[2][2] <= a_cxcy;
    end
  end

  // stage C: scale products and pivot dot terms
  logic                 vcc;
  logic signed [PW-1:0] ps [3][3];
  logic signed [PW-1:0] pd [3][3];
  logic signed [31:0]   c_op [3];
  logic signed [31:0]   c_p [3];
  logic signed [31:0]   sv [3];

  assign sv[0] = sb.sx;
  assign sv[1] = sb.sy;
  assign sv[2] = sb.sz;

  always_ff @(posedge clk) begin
    if (rst) vcc <= 1'b0;
    else if (en) vcc <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_op   <= b_op;
      c_p[0] <= sb.px;
      c_p[1] <= sb.py;
      c_p[2] <= sb.pz;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ps[i][j] <= PW'(rm[i][j]) * PW'(sv[j]);
          pd[i][j] <= PW'(rm[i][j]) * PW'(b_op[j]);
        end
      end
    end
  end

  // stage D: round, sum, saturate into the output register
  logic signed [31:0] ro [3][3];
  logic signed [31:0] tr [3];
  logic signed [PW-1:0] dot [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i] = rnd(pd[i][0] + pd[i][1] + pd[i][2], FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vcc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) ro[i][j] <= sat32(rnd(ps[i][j], FRAC_BITS));
        tr[i] <= sat32(PW'(c_p[i]) + PW'(c_op[i]) - dot[i]);
      end
    end
  end

  assign r00 = ro[0][0];
  assign r01 = ro[0][1];
  assign r02 = ro[0][2];
  assign r10 = ro[1][0];
  assign r11 = ro[1][1];
  assign r12 = ro[1][2];
  assign r20 = ro[2][0];
  assign r21 = ro[2][1];
  assign r22 = ro[2][2];
  assign trans_x = tr[0];
  assign trans_y = tr[1];
  assign trans_z = tr[2];

endmodule
